/* design/irpw_pkg.sv */
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared types and constants for the IR pulse-width frame decoder.
// ----------------------------------------------------------------------------
package irpw_pkg;

   // Field widths.
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 8;

   // Number of data bits in one frame.
   localparam int unsigned FRAME_BITS = 32;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_MAX     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_MIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_MIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_LOW  = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [BYTE_W-1:0] SYNC_MAX_RESET     = 8'd30;
   localparam logic [BYTE_W-1:0] SYNC_MIN_RESET     = 8'd3;
   localparam logic [BYTE_W-1:0] ONE_MIN_RESET      = 8'd12;
   localparam logic [BYTE_W-1:0] ADDRESS_HIGH_RESET = 8'h12;
   localparam logic [BYTE_W-1:0] ADDRESS_LOW_RESET  = 8'h34;

   // Command plus inverted command must sum to this value.
   localparam logic [BYTE_W:0] COMMAND_SUM = 9'h0FF;

   // Configuration register set.
   typedef struct packed {
      logic [BYTE_W-1:0] sync_max;
      logic [BYTE_W-1:0] sync_min;
      logic [BYTE_W-1:0] one_min;
      logic [BYTE_W-1:0] address_high;
      logic [BYTE_W-1:0] address_low;
   } cfg_type;

   // Decoder state carried from one sample to the next.
   typedef struct packed {
      logic               was_high;
      logic [COUNT_W-1:0] width_count;
      logic [COUNT_W-1:0] bits_left;
      logic [WORD_W-1:0]  shift_word;
   } state_type;

   // One result item.
   typedef struct packed {
      logic              frame_done;
      logic              frame_ok;
      logic [BYTE_W-1:0] command;
      logic [WORD_W-1:0] frame_word;
   } result_type;

endpackage

/* design/ir_pulse_width_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_decoder_core
// Decodes 32-bit pulse-width IR remote frames from one line sample per
// transfer and returns one result per sample.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                               Carries
//  req       in         req_valid/req_ready, req_line_level one line sample
//  rsp       out        rsp_valid/rsp_ready, rsp_*          one result per sample
//  csr       in         csr_valid/csr_ready, csr_index/data register write
//
//  The step logic runs between the state registers and the result
//  register, so a new sample is taken every cycle while req_ready is high.
//  A result appears in the cycle after its sample transfer.
//  Reset clears the state and loads the register defaults; no clearing pass.
//  A stalled result holds in the output register; req_ready stays high as
//  long as that register is empty or is being read in the same cycle.
//  Register writes are taken in every cycle.
// ----------------------------------------------------------------------------
module ir_pulse_width_frame_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   // Sample input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_line_level,
   // Result output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_frame_done,
   output logic                              rsp_frame_ok,
   output logic [irpw_pkg::BYTE_W-1:0]       rsp_command,
   output logic [irpw_pkg::WORD_W-1:0]       rsp_frame_word,
   // Register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [irpw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [irpw_pkg::CSR_DATA_W-1:0]   csr_data
);

   irpw_pkg::cfg_type    cfg_ff, cfg_in;
   irpw_pkg::state_type  state_ff, state_in, state_next;
   irpw_pkg::result_type result_ff, result_in, result_next;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_xfer;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   // Register file writes; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            irpw_pkg::CSR_SYNC_MAX:     cfg_in.sync_max     = csr_data;
            irpw_pkg::CSR_SYNC_MIN:     cfg_in.sync_min     = csr_data;
            irpw_pkg::CSR_ONE_MIN:      cfg_in.one_min      = csr_data;
            irpw_pkg::CSR_ADDRESS_HIGH: cfg_in.address_high = csr_data;
            irpw_pkg::CSR_ADDRESS_LOW:  cfg_in.address_low  = csr_data;
            default: ;
         endcase
      end
   end

   // Per-sample decode step.
   irpw_step u_step (
      .line_level (req_line_level),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_next),
      .result     (result_next)
   );

   // State and output register updates.
   always_comb begin
      state_in     = state_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_xfer) begin
         state_in     = state_next;
         result_in    = result_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_max     <= irpw_pkg::SYNC_MAX_RESET;
         cfg_ff.sync_min     <= irpw_pkg::SYNC_MIN_RESET;
         cfg_ff.one_min      <= irpw_pkg::ONE_MIN_RESET;
         cfg_ff.address_high <= irpw_pkg::ADDRESS_HIGH_RESET;
         cfg_ff.address_low  <= irpw_pkg::ADDRESS_LOW_RESET;
         state_ff            <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_done = result_ff.frame_done;
   assign rsp_frame_ok   = result_ff.frame_ok;
   assign rsp_command    = result_ff.command;
   assign rsp_frame_word = result_ff.frame_word;

   // A frame can only pass its check on the sample that completes it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> rsp_frame_done)
      else $error("frame_ok without frame_done");

   // The command output is always bits 15:8 of the shown word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_command == rsp_frame_word[15:8])
      else $error("command does not match frame word");

   // A high sample leaves the line marked high.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_line_level |=> state_ff.was_high)
      else $error("high sample not recorded");

   // A low sample clears the width counter and the high flag.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req_line_level |=> !state_ff.was_high && state_ff.width_count == '0)
      else $error("low sample did not clear width state");

   // A result is shown in the cycle after every accepted sample.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("accepted sample produced no result");

endmodule

/* design/irpw_step.sv */
// ----------------------------------------------------------------------------
// irpw_step
// Next-state and result logic for one line sample: width counting, edge
// classification, bit shifting and frame check.
// ----------------------------------------------------------------------------
module irpw_step (
   input  logic                  line_level,
   input  irpw_pkg::cfg_type     cfg,
   input  irpw_pkg::state_type   state,
   output irpw_pkg::state_type   state_next,
   output irpw_pkg::result_type  result
);

   logic [irpw_pkg::COUNT_W-1:0] width_inc;
   logic                         is_sync;
   logic                         is_one;
   logic [irpw_pkg::COUNT_W-1:0] bits_dec;
   logic                         done;
   logic [irpw_pkg::BYTE_W:0]    cmd_sum;
   logic [irpw_pkg::WORD_W-1:0]  word;

   // Width count including this sample, wrapping at 256.
   assign width_inc = state.width_count + 8'd1;
   assign is_sync   = (width_inc > cfg.sync_max) || (width_inc < cfg.sync_min);
   assign is_one    = (width_inc >= cfg.one_min);
   assign bits_dec  = state.bits_left - 8'd1;

   // Update the state on the sample.
   always_comb begin
      state_next = state;
      done       = 1'b0;
      if (line_level) begin
         state_next.was_high    = 1'b1;
         state_next.width_count = width_inc;
      end else begin
         if (state.was_high) begin
            if (is_sync) begin
               state_next.bits_left  = irpw_pkg::COUNT_W'(irpw_pkg::FRAME_BITS);
               state_next.shift_word = '0;
            end else begin
               state_next.shift_word = {state.shift_word[irpw_pkg::WORD_W-2:0], is_one};
               state_next.bits_left  = bits_dec;
               done                  = (bits_dec == '0);
            end
         end
         state_next.was_high    = 1'b0;
         state_next.width_count = '0;
      end
   end

   // Frame check on the completed word.
   assign word    = state_next.shift_word;
   assign cmd_sum = {1'b0, word[15:8]} + {1'b0, word[7:0]};

   always_comb begin
      result.frame_done = done;
      result.frame_ok   = done && (word[31:24] == cfg.address_high)
                               && (word[23:16] == cfg.address_low)
                               && (cmd_sum == irpw_pkg::COMMAND_SUM);
      result.command    = word[15:8];
      result.frame_word = word;
   end

endmodule
